/* rtl/crw_pkg.sv */
// ----------------------------------------------------------------------------
// crw_pkg - shared definitions for the chunk reorder window
// Status codes, window geometry, word layout and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package crw_pkg;

  // Reorder window depth. Slot selection is a plain mask of the chunk number,
  // so the depth stays a power of two.
  localparam int unsigned WINDOW = 64;
  localparam int unsigned SLOT_W = $clog2(WINDOW);

  // Field widths.
  localparam int unsigned CHUNK_W  = 32;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned AMOUNT_W = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Result word layout, lowest bit first.
  localparam int unsigned OUT_ID_LSB   = 0;
  localparam int unsigned OUT_SLOT_LSB = OUT_ID_LSB + CHUNK_W;
  localparam int unsigned OUT_LEN_LSB  = OUT_SLOT_LSB + SLOT_W;
  localparam int unsigned OUT_REQ_LSB  = OUT_LEN_LSB + LEN_W;
  localparam int unsigned OUT_AMT_LSB  = OUT_REQ_LSB + CHUNK_W;
  localparam int unsigned OUT_USED_W   = OUT_AMT_LSB + AMOUNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DELIVER = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DRAIN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STALE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FAR     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_REQ     = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_COUNT = 2'd2;

  // Input operation codes.
  localparam logic OP_CHUNK = 1'b0;
  localparam logic OP_TIMER = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic take_item;   // load the first result of the presented input word
    logic take_drain;  // load the next buffered chunk of a drain
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;      // output register can be loaded this cycle
    logic item_chains;   // presented item is a delivery with a buffered successor
    logic drain_chains;  // the buffered chunk being drained has a successor
  } sts_t;

endpackage

/* rtl/chunk_reorder_window_core.sv */
// ----------------------------------------------------------------------------
// chunk_reorder_window_core - receive reorder window for numbered chunks
// Classifies each arriving chunk against the expected number, tracks which
// window slots hold buffered chunks and releases them in order.
// ----------------------------------------------------------------------------
//
//   channel  direction  words                     fields
//   in_      slave      one per event             tuser: operation, tdata: chunk_number
//   out_     master     1 to 64 per input word    tuser: status, tdata: result, tlast
//   cfg_     slave      one per register write    cfg_index, cfg_data
//
// An input word is classified in the cycle it is accepted and its first
// result is in the output register in the following cycle. A delivery that
// finds buffered successors continues with one drained chunk per cycle while
// the output is not stalled, until the first empty slot; the next input word
// is accepted once the last result of the run has been loaded. Reset (rst_n
// low, synchronous) empties every slot, sets the expected number to zero and
// restores the register defaults; no clearing pass is needed. A stalled
// out_tready holds the output register and the sequencer, and in_tready stays
// low throughout.
// Configuration words are always taken and are meant to arrive while idle.
// ----------------------------------------------------------------------------
module chunk_reorder_window_core #(
  parameter int unsigned CHUNK_BYTES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input words.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [crw_pkg::CHUNK_W-1:0]       in_tdata,   // [31:0] chunk_number
  input  logic [0:0]                        in_tuser,   // [0] operation
  // Result words.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] chunk_id, [37:32] slot, [48:38] byte_length, [80:49] request_chunk,
  // [88:81] request_amount, [95:89] zero
  output logic [crw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [crw_pkg::STATUS_W-1:0]      out_tuser,  // [2:0] status
  output logic                              out_tlast,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crw_pkg::CHUNK_W-1:0]       cfg_data
);
  import crw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Register writes are always accepted, so the port never stalls.
  assign cfg_ready = 1'b1;

  // The sequencer owns the input handshake and decides when a result is
  // loaded; everything it decides on comes back from the datapath as status.
  crw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath keeps the window state and the output register. The drain
  // ends by itself within the window: the delivered chunk's own slot is
  // cleared first, so at most WINDOW-1 successors can follow it.
  crw_dpath #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/crw_ctrl.sv */
// ----------------------------------------------------------------------------
// crw_ctrl - run sequencer of the chunk reorder window
// Accepts one input word at a time and steps through the in-order drain
// that follows a delivery, one result per cycle while the output register is free.
// ----------------------------------------------------------------------------
module crw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  crw_pkg::sts_t  sts,
  output crw_pkg::cmd_t  cmd
);
  import crw_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_tready     = sts.out_free;
        cmd.take_item = in_tvalid && sts.out_free;
        if (cmd.take_item && sts.item_chains) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.take_drain = sts.out_free;
        if (sts.out_free && !sts.drain_chains) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/crw_dpath.sv */
// ----------------------------------------------------------------------------
// crw_dpath - datapath of the chunk reorder window
// Holds the configuration, the expected chunk number, the slot occupancy
// flags and the output register, and classifies each arriving word.
// ----------------------------------------------------------------------------
module crw_dpath #(
  parameter int unsigned CHUNK_BYTES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  crw_pkg::cmd_t                         cmd,
  output crw_pkg::sts_t                         sts,
  input  logic [crw_pkg::CHUNK_W-1:0]           in_tdata,
  input  logic [0:0]                            in_tuser,
  input  logic                                  cfg_valid,
  input  logic [crw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [crw_pkg::CHUNK_W-1:0]           cfg_data,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [crw_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [crw_pkg::STATUS_W-1:0]          out_tuser,
  output logic                                  out_tlast
);
  import crw_pkg::*;

  // Ordinary chunk length, saturated to the width of the length field.
  localparam int unsigned BODY_LEN_I = (CHUNK_BYTES > 2047) ? 2047 : CHUNK_BYTES;
  localparam logic [LEN_W-1:0] BODY_LEN = LEN_W'(BODY_LEN_I);

  // Configuration, with the index of the final chunk kept ready.
  logic [CHUNK_W-1:0]  chunk_total_r;
  logic [CHUNK_W-1:0]  final_idx_r;
  logic                total_nz_r;
  logic [LEN_W-1:0]    last_length_r;
  logic [AMOUNT_W-1:0] request_count_r;

  // Window state.
  logic [CHUNK_W-1:0] next_exp_r;
  logic [CHUNK_W-1:0] next_exp_nxt;
  logic [WINDOW-1:0]  slot_full_r;
  logic [WINDOW-1:0]  slot_full_nxt;

  // Output register.
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] o_status_r;
  logic [CHUNK_W-1:0]  o_id_r;
  logic [SLOT_W-1:0]   o_slot_r;
  logic [LEN_W-1:0]    o_len_r;
  logic [CHUNK_W-1:0]  o_rchunk_r;
  logic [AMOUNT_W-1:0] o_ramt_r;
  logic                o_last_r;

  // Item classification.
  logic                op;
  logic [CHUNK_W-1:0]  c;
  logic [SLOT_W-1:0]   c_slot;
  logic [SLOT_W-1:0]   c_succ;
  logic [CHUNK_W:0]    diff_w;
  logic                behind;
  logic                is_next;
  logic                in_window;
  logic                past_total;
  logic                c_final;

  logic [STATUS_W-1:0] it_status;
  logic [CHUNK_W-1:0]  it_id;
  logic [SLOT_W-1:0]   it_slot;
  logic [LEN_W-1:0]    it_len;
  logic [CHUNK_W-1:0]  it_rchunk;
  logic [AMOUNT_W-1:0] it_ramt;
  logic                it_last;

  // Drain step.
  logic [SLOT_W-1:0]   ne_slot;
  logic [SLOT_W-1:0]   ne_succ;
  logic                ne_final;
  logic                dr_last;

  assign op      = in_tuser[0];
  assign c       = in_tdata;
  assign c_slot  = c[SLOT_W-1:0];
  assign c_succ  = c_slot + SLOT_W'(1);
  assign diff_w  = {1'b0, c} - {1'b0, next_exp_r};
  assign behind  = diff_w[CHUNK_W];
  assign is_next = (diff_w[CHUNK_W-1:0] == '0) && !behind;
  assign in_window  = !behind && (diff_w[CHUNK_W-1:SLOT_W] == '0);
  assign past_total = (c >= chunk_total_r);
  assign c_final    = total_nz_r && (c == final_idx_r);

  assign ne_slot  = next_exp_r[SLOT_W-1:0];
  assign ne_succ  = ne_slot + SLOT_W'(1);
  assign ne_final = total_nz_r && (next_exp_r == final_idx_r);
  assign dr_last  = !slot_full_r[ne_succ];

  always_comb begin
    it_status = ST_FAR;
    it_id     = c;
    it_slot   = '0;
    it_len    = '0;
    it_rchunk = '0;
    it_ramt   = '0;
    it_last   = 1'b1;
    if (op == OP_TIMER) begin
      it_status = ST_REQ;
      it_id     = next_exp_r;
      it_rchunk = next_exp_r;
      it_ramt   = request_count_r;
    end else if (past_total) begin
      it_status = ST_FAR;
    end else if (behind) begin
      it_status = ST_STALE;
    end else if (is_next) begin
      it_status = ST_DELIVER;
      it_slot   = c_slot;
      it_len    = c_final ? last_length_r : BODY_LEN;
      it_last   = !slot_full_r[c_succ];
    end else if (in_window) begin
      it_slot = c_slot;
      if (slot_full_r[c_slot]) begin
        it_status = ST_DUP;
      end else begin
        it_status = ST_STORED;
        it_len    = c_final ? last_length_r : BODY_LEN;
      end
    end
  end

  assign sts.out_free     = !out_valid_r || out_tready;
  assign sts.item_chains  = !it_last;
  assign sts.drain_chains = !dr_last;

  always_comb begin
    next_exp_nxt  = next_exp_r;
    slot_full_nxt = slot_full_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.take_item) begin
      out_valid_nxt = 1'b1;
      if (it_status == ST_DELIVER) begin
        next_exp_nxt          = c + CHUNK_W'(1);
        slot_full_nxt[c_slot] = 1'b0;
      end else if (it_status == ST_STORED) begin
        slot_full_nxt[c_slot] = 1'b1;
      end
    end else if (cmd.take_drain) begin
      out_valid_nxt          = 1'b1;
      next_exp_nxt           = next_exp_r + CHUNK_W'(1);
      slot_full_nxt[ne_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_total_r   <= '0;
      final_idx_r     <= '1;
      total_nz_r      <= 1'b0;
      last_length_r   <= '0;
      request_count_r <= AMOUNT_W'(8);
      next_exp_r      <= '0;
      slot_full_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CHUNK_TOTAL: begin
            chunk_total_r <= cfg_data;
            final_idx_r   <= cfg_data - CHUNK_W'(1);
            total_nz_r    <= (cfg_data != '0);
          end
          CFG_LAST_LENGTH: begin
            last_length_r <= cfg_data[LEN_W-1:0];
          end
          CFG_REQUEST_COUNT: begin
            request_count_r <= cfg_data[AMOUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      next_exp_r  <= next_exp_nxt;
      slot_full_r <= slot_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      o_status_r <= it_status;
      o_id_r     <= it_id;
      o_slot_r   <= it_slot;
      o_len_r    <= it_len;
      o_rchunk_r <= it_rchunk;
      o_ramt_r   <= it_ramt;
      o_last_r   <= it_last;
    end else if (cmd.take_drain) begin
      o_status_r <= ST_DRAIN;
      o_id_r     <= next_exp_r;
      o_slot_r   <= ne_slot;
      o_len_r    <= ne_final ? last_length_r : BODY_LEN;
      o_rchunk_r <= '0;
      o_ramt_r   <= '0;
      o_last_r   <= dr_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), o_ramt_r, o_rchunk_r, o_len_r,
                       o_slot_r, o_id_r};

  // The sequencer never asks for two results in one cycle.
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take_item && cmd.take_drain))
    else $error("item and drain loaded together");

  // A drain step only ever releases an occupied slot.
  a_drain_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_drain |-> slot_full_r[ne_slot])
    else $error("drain step on an empty slot");

  // A delivery moves the expected number one past the delivered chunk.
  a_deliver_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_item && it_status == ST_DELIVER) |=> (next_exp_r == $past(c) + CHUNK_W'(1)))
    else $error("expected number not advanced after delivery");

  // Results are loaded only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_item || cmd.take_drain) |-> sts.out_free)
    else $error("result loaded over a pending one");

endmodule
